### sv/tcw_pkg.sv
// Package with shared types, constants and commands for the text console writer.
package tcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TERMINALS = 4;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int DEPTH     = TERMINALS * CELLS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int TERM_W = 2;
    localparam int CELL_W = $clog2(CELLS);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int OFS_W  = 11;

    localparam logic [7:0]  DEF_ATTR   = 8'h07;
    localparam logic [7:0]  BLANK_CHAR = 8'h20;
    localparam logic [15:0] BLANK_CELL = {DEF_ATTR, BLANK_CHAR};
    localparam logic [7:0]  CHAR_LF    = 8'd10;
    localparam logic [7:0]  CHAR_CR    = 8'd13;

    localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
    localparam logic [CELL_W-1:0] ROW_CELLS = CELL_W'(COLUMNS);
    localparam logic [CELL_W-1:0] LAST_ROW_START = CELL_W'(CELLS - COLUMNS);

    typedef enum logic [3:0] {
        CMD_PUT   = 4'd0,
        CMD_BS    = 4'd1,
        CMD_CLR   = 4'd2,
        CMD_CLRH  = 4'd3,
        CMD_HOME  = 4'd4,
        CMD_SETC  = 4'd5,
        CMD_MATTR = 4'd6,
        CMD_SHOW  = 4'd7,
        CMD_READ  = 4'd8
    } cmd_t;

    localparam logic CFG_WRITE_TERM  = 1'b0;
    localparam logic CFG_CURSOR_TERM = 1'b1;

    typedef struct packed {
        logic [3:0]       cmd;
        logic [7:0]       char_code;
        logic             line_full;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       attr_value;
        logic [1:0]       buffer_sel;
    } in_word_t;

    typedef struct packed {
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic [OFS_W-1:0] cursor_offset;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
    } out_word_t;

    // Memory operations commanded by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,   // write wdata at current term/cell
        OP_ATTR,    // read-modify-write attribute
        OP_READ,    // read a cell for the result
        OP_FILL,    // sweep: blank every cell
        OP_SCROLL,  // sweep: shift rows up
        OP_COPY     // sweep: copy terminal to display
    } mem_op_t;

    typedef struct packed {
        mem_op_t          op;
        logic [TERM_W-1:0] term;
        logic [CELL_W-1:0] cell_ofs;
        logic [15:0]       wdata;
        logic [7:0]        attr;
    } dp_cmd_t;

    typedef struct packed {
        logic        busy;
        logic [15:0] rdata;
    } dp_status_t;

    function automatic logic [CELL_W-1:0] cell_index(logic [ROW_W-1:0] r,
                                                     logic [COL_W-1:0] c);
        logic [CELL_W+COL_W-1:0] p;
        p = (CELL_W+COL_W)'(r * COLUMNS);
        return CELL_W'(p) + CELL_W'(c);
    endfunction

endpackage

### sv/tcw_datapath.sv
// Cell store memory with its sweep engine for fill, scroll and copy.
module tcw_datapath
    import tcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_cmd_t    cmd,
    output dp_status_t status
);

    logic [15:0] mem [DEPTH];

    typedef enum logic [4:0] {
        D_CLEAR = 5'b00001,
        D_IDLE  = 5'b00010,
        D_RD    = 5'b00100,
        D_SWEEP = 5'b01000,
        D_WAIT  = 5'b10000
    } dstate_t;

    dstate_t state_reg, state_next;
    mem_op_t op_reg, op_next;
    logic [TERM_W-1:0] term_reg, term_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [7:0] attr_reg, attr_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [15:0] wdata;
    logic        we;
    logic [15:0] rdata_reg;
    logic [CELL_W-1:0] src_cell;

    function automatic logic [ADDR_W-1:0] addr_of(logic [TERM_W-1:0] t,
                                                  logic [CELL_W-1:0] c);
        logic [ADDR_W+CELL_W-1:0] p;
        p = (ADDR_W+CELL_W)'(t * CELLS);
        return ADDR_W'(p) + ADDR_W'(c);
    endfunction

    // Read data is held while idle so that a finished read stays visible.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (state_reg != D_IDLE || start)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign status.busy  = (state_reg != D_IDLE);
    assign status.rdata = rdata_reg;
    assign src_cell = cell_reg + ROW_CELLS;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        term_next  = term_reg;
        cell_next  = cell_reg;
        attr_next  = attr_reg;
        clr_next   = clr_reg;
        we    = 1'b0;
        waddr = addr_of(term_reg, cell_reg);
        raddr = addr_of(term_reg, cell_reg);
        wdata = BLANK_CELL;
        unique case (state_reg)
            D_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = D_IDLE;
                end
            end
            D_IDLE:
            begin
                raddr = addr_of(cmd.term, cmd.cell_ofs);
                if (start)
                begin
                    op_next   = cmd.op;
                    term_next = cmd.term;
                    attr_next = cmd.attr;
                    cell_next = cmd.cell_ofs;
                    unique case (cmd.op) inside
                        OP_WRITE:
                        begin
                            we    = 1'b1;
                            waddr = addr_of(cmd.term, cmd.cell_ofs);
                            wdata = cmd.wdata;
                        end
                        OP_ATTR, OP_READ: state_next = D_RD;
                        OP_FILL:
                        begin
                            cell_next  = '0;
                            state_next = D_SWEEP;
                        end
                        OP_SCROLL, OP_COPY:
                        begin
                            cell_next  = '0;
                            state_next = D_WAIT;
                        end
                        default: ;
                    endcase
                end
            end
            D_RD:
            begin
                // Read data for the addressed cell is now registered.
                if (op_reg == OP_ATTR)
                begin
                    we    = 1'b1;
                    wdata = {attr_reg, rdata_reg[7:0]};
                end
                state_next = D_IDLE;
            end
            D_WAIT:
            begin
                // Issue read of the source cell.
                if (op_reg == OP_SCROLL)
                begin
                    raddr = addr_of(term_reg, src_cell);
                end
                state_next = D_SWEEP;
            end
            D_SWEEP:
            begin
                we = 1'b1;
                if (op_reg == OP_FILL)
                begin
                    wdata = BLANK_CELL;
                end
                else if (op_reg == OP_SCROLL)
                begin
                    wdata = (cell_reg >= LAST_ROW_START) ? BLANK_CELL
                                                         : {DEF_ATTR, rdata_reg[7:0]};
                end
                else
                begin
                    waddr = addr_of('0, cell_reg);
                    wdata = rdata_reg;
                end
                cell_next = cell_reg + 1'b1;
                if (cell_reg == LAST_CELL)
                begin
                    state_next = D_IDLE;
                end
                else if (op_reg != OP_FILL)
                begin
                    state_next = D_WAIT;
                    cell_next  = cell_reg + 1'b1;
                end
            end
            default: state_next = D_IDLE;
        endcase
        if (state_reg == D_WAIT && op_reg == OP_COPY)
        begin
            raddr = addr_of(term_reg, cell_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_CLEAR;
            clr_reg   <= '0;
            op_reg    <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
        cell_reg <= cell_next;
        attr_reg <= attr_next;
    end

endmodule

### sv/tcw_ctrl.sv
// Command controller: cursors, configuration and result word sequencing.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    output logic        dp_start,
    output dp_cmd_t     dp_cmd,
    input  dp_status_t  dp_status
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_WAIT   = 5'b00010,
        S_SCROLL = 5'b00100,
        S_DONE   = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [COL_W-1:0] ccol_reg [TERMINALS];
    logic [ROW_W-1:0] crow_reg [TERMINALS];
    logic [COL_W-1:0] ccol_next [TERMINALS];
    logic [ROW_W-1:0] crow_next [TERMINALS];
    logic [TERM_W-1:0] wterm_reg, cterm_reg;
    logic is_read_reg, is_read_next;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] ncol;
    logic [ROW_W-1:0] nrow;
    logic [OFS_W-1:0] ofs;
    logic need_scroll;
    logic in_range;

    assign in_ready  = (state_reg == S_IDLE) && !dp_status.busy;
    assign out_valid = (state_reg == S_OUT);
    assign cfg_ready = 1'b1;
    assign cur_col = ccol_reg[wterm_reg];
    assign cur_row = crow_reg[wterm_reg];
    assign in_range = (in_data.col < COL_W'(COLUMNS)) && (in_data.row < ROW_W'(ROWS));

    always_comb
    begin
        state_next   = state_reg;
        is_read_next = is_read_reg;
        ccol_next    = ccol_reg;
        crow_next    = crow_reg;
        dp_start     = 1'b0;
        dp_cmd.op    = OP_NONE;
        dp_cmd.term  = wterm_reg;
        dp_cmd.cell_ofs = cell_index(cur_row, cur_col);
        dp_cmd.wdata = {DEF_ATTR, in_data.char_code};
        dp_cmd.attr  = in_data.attr_value;
        ncol = cur_col;
        nrow = cur_row;
        need_scroll = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    is_read_next = 1'b0;
                    state_next   = S_WAIT;
                    unique case (in_data.cmd) inside
                        CMD_PUT:
                        begin
                            if (in_data.char_code == CHAR_LF ||
                                in_data.char_code == CHAR_CR)
                            begin
                                ncol = '0;
                                need_scroll = (cur_row == LAST_ROW);
                                nrow = need_scroll ? cur_row : cur_row + 1'b1;
                            end
                            else
                            begin
                                dp_start  = 1'b1;
                                dp_cmd.op = OP_WRITE;
                                if (cur_col == LAST_COL)
                                begin
                                    ncol = '0;
                                    need_scroll = (cur_row == LAST_ROW);
                                    nrow = need_scroll ? cur_row : cur_row + 1'b1;
                                end
                                else
                                begin
                                    ncol = cur_col + 1'b1;
                                end
                            end
                            if (need_scroll)
                            begin
                                state_next = S_SCROLL;
                            end
                        end
                        CMD_BS:
                        begin
                            if (cur_col != '0)
                            begin
                                ncol = cur_col - 1'b1;
                            end
                            else if (in_data.line_full && cur_row != '0)
                            begin
                                ncol = LAST_COL;
                                nrow = cur_row - 1'b1;
                            end
                            dp_start     = 1'b1;
                            dp_cmd.op    = OP_WRITE;
                            dp_cmd.cell_ofs = cell_index(nrow, ncol);
                            dp_cmd.wdata = BLANK_CELL;
                        end
                        CMD_CLR, CMD_CLRH:
                        begin
                            dp_start  = 1'b1;
                            dp_cmd.op = OP_FILL;
                            if (in_data.cmd == CMD_CLRH)
                            begin
                                ncol = '0;
                                nrow = '0;
                            end
                        end
                        CMD_HOME:
                        begin
                            ncol = '0;
                            nrow = '0;
                        end
                        CMD_SETC:
                        begin
                            ncol = (in_data.col < COL_W'(COLUMNS)) ? in_data.col : LAST_COL;
                            nrow = (in_data.row < ROW_W'(ROWS)) ? in_data.row : LAST_ROW;
                        end
                        CMD_MATTR:
                        begin
                            if (in_range)
                            begin
                                dp_start    = 1'b1;
                                dp_cmd.op   = OP_ATTR;
                                dp_cmd.cell_ofs = cell_index(in_data.row, in_data.col);
                            end
                        end
                        CMD_SHOW:
                        begin
                            dp_start  = 1'b1;
                            dp_cmd.op = OP_COPY;
                        end
                        CMD_READ:
                        begin
                            if (in_range && 32'(in_data.buffer_sel) < TERMINALS)
                            begin
                                is_read_next = 1'b1;
                                dp_start     = 1'b1;
                                dp_cmd.op    = OP_READ;
                                dp_cmd.term  = in_data.buffer_sel;
                                dp_cmd.cell_ofs = cell_index(in_data.row, in_data.col);
                            end
                        end
                        default: ;
                    endcase
                    ccol_next[wterm_reg] = ncol;
                    crow_next[wterm_reg] = nrow;
                end
            end
            S_SCROLL:
            begin
                // Once the datapath is idle, any write of the character has finished; start the scroll.
                if (!dp_status.busy)
                begin
                    dp_start   = 1'b1;
                    dp_cmd.op  = OP_SCROLL;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!dp_status.busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ofs = OFS_W'(crow_reg[cterm_reg] * COLUMNS) + OFS_W'(ccol_reg[cterm_reg]);
        out_data.cursor_col    = ccol_reg[cterm_reg];
        out_data.cursor_row    = crow_reg[cterm_reg];
        out_data.cursor_offset = ofs;
        out_data.cell_char     = is_read_reg ? dp_status.rdata[7:0] : 8'h00;
        out_data.cell_attr     = is_read_reg ? dp_status.rdata[15:8] : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            is_read_reg <= 1'b0;
            wterm_reg   <= TERM_W'(1);
            cterm_reg   <= TERM_W'(1);
            for (int i = 0; i < TERMINALS; i++)
            begin
                ccol_reg[i] <= '0;
                crow_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            is_read_reg <= is_read_next;
            ccol_reg    <= ccol_next;
            crow_reg    <= crow_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_WRITE_TERM)
                begin
                    if (cfg_data != '0 && 32'(cfg_data) < TERMINALS)
                    begin
                        wterm_reg <= cfg_data;
                    end
                end
                else if (32'(cfg_data) < TERMINALS)
                begin
                    cterm_reg <= cfg_data;
                end
            end
        end
    end

endmodule

### sv/text_console_writer.sv
// Top level of the text console writer: controller plus cell store datapath.
// Text-mode console with an 80x25 cell store for the display (buffer 0) and
// three terminals, each with its own cursor. Each accepted input word gives
// exactly one result word that carries the cursor of the cursor terminal after
// the command, and the cell contents for a read. Simple commands offer their
// result word after the controller's wait and done states (read cell and mouse
// attribute wait longer, since they read the cell memory first), and no
// input word is taken until the result word leaves. Clear and show sweep the
// 2000 cells of a buffer through the cell memory, one cell per cycle for
// clear, while show and scroll alternate a read state and a write state for
// each cell. After reset the block clears all 8000 cells, one per cycle, and
// takes no input word until that pass is done; the configuration port is
// always ready. Register 0 selects the write terminal (1 to 3) and register 1
// the cursor terminal (0 to 3); illegal values are ignored.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data
);

    logic       dp_start;
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dp_start  (dp_start),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    tcw_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (dp_start),
        .cmd    (dp_cmd),
        .status (dp_status)
    );

endmodule

### sv/tcw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
module tcw_checker
    import tcw_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    // A result word is never offered while a new input word is taken.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while result pending");

    // A result word never follows an accepted input word immediately.
    a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid)
        else $error("result in the cycle after acceptance");

    // The reported cursor lies on the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.cursor_col < COL_W'(COLUMNS) &&
                       out_data.cursor_row < ROW_W'(ROWS)))
        else $error("cursor out of range");

    // A stalled result word holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed while stalled");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### tb/text_console_writer_test.sv
// Self-checking testbench for the text console writer: predictor, driver and monitor.
`timescale 1ns / 100ps

module text_console_writer_test;
    import tcw_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_index;
    logic [1:0] cfg_data;

    text_console_writer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the console: every buffer, every cursor and both registers.
    logic [15:0]      shadow_cells [DEPTH];
    logic [COL_W-1:0] shadow_col [TERMINALS];
    logic [ROW_W-1:0] shadow_row [TERMINALS];
    int unsigned      shadow_wterm;
    int unsigned      shadow_cterm;

    in_word_t  pending_words [$];
    out_word_t expected_words [$];
    int        error_count;

    // Words handed to the block and result words checked so far.
    int        sent_count = 0;
    int        checked_count = 0;

    // Long receiver hold-off requested by the stimulus thread.
    bit        hold_go = 1'b0;
    bit        hold_active = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Counts out the long hold-off of the receiver.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (300) @(posedge clk);
        hold_active <= 1'b0;
    end

    function automatic void blank_buffer(int unsigned t);
        for (int i = 0; i < CELLS; i++)
            shadow_cells[t * CELLS + i] = BLANK_CELL;
    endfunction

    // Applies one command to the shadow state and returns the result word.
    function automatic out_word_t console_step(in_word_t w);
        int unsigned t;
        int unsigned base;
        int unsigned c;
        int unsigned r;
        out_word_t   res;
        t = shadow_wterm;
        base = t * CELLS;
        res = '0;
        case (w.cmd)
            CMD_PUT:
            begin
                c = shadow_col[t];
                r = shadow_row[t];
                if (w.char_code == CHAR_LF || w.char_code == CHAR_CR)
                begin
                    r++;
                    c = 0;
                end
                else
                begin
                    shadow_cells[base + r * COLUMNS + c] = {DEF_ATTR, w.char_code};
                    c++;
                    if (c >= COLUMNS)
                    begin
                        c = 0;
                        r++;
                    end
                end
                // Running off the bottom scrolls the buffer and resets all attributes.
                if (r > ROWS - 1)
                begin
                    r = ROWS - 1;
                    for (int i = 0; i < CELLS; i++)
                        shadow_cells[base + i] = {DEF_ATTR, (i + COLUMNS < CELLS) ?
                            shadow_cells[base + i + COLUMNS][7:0] : BLANK_CHAR};
                end
                shadow_col[t] = COL_W'(c);
                shadow_row[t] = ROW_W'(r);
            end
            CMD_BS:
            begin
                if (shadow_col[t] > 0)
                    shadow_col[t]--;
                else if (w.line_full && shadow_row[t] > 0)
                begin
                    shadow_col[t] = LAST_COL;
                    shadow_row[t]--;
                end
                shadow_cells[base + shadow_row[t] * COLUMNS + shadow_col[t]] = BLANK_CELL;
            end
            CMD_CLR:
                blank_buffer(t);
            CMD_CLRH:
            begin
                blank_buffer(t);
                shadow_col[t] = '0;
                shadow_row[t] = '0;
            end
            CMD_HOME:
            begin
                shadow_col[t] = '0;
                shadow_row[t] = '0;
            end
            CMD_SETC:
            begin
                shadow_col[t] = (w.col < COLUMNS) ? w.col : LAST_COL;
                shadow_row[t] = (w.row < ROWS) ? w.row : LAST_ROW;
            end
            CMD_MATTR:
                if (w.col < COLUMNS && w.row < ROWS)
                    shadow_cells[base + w.row * COLUMNS + w.col][15:8] = w.attr_value;
            CMD_SHOW:
                for (int i = 0; i < CELLS; i++)
                    shadow_cells[i] = shadow_cells[base + i];
            CMD_READ:
                if (w.col < COLUMNS && w.row < ROWS && w.buffer_sel < TERMINALS)
                    {res.cell_attr, res.cell_char} =
                        shadow_cells[w.buffer_sel * CELLS + w.row * COLUMNS + w.col];
            default:
                ;
        endcase
        res.cursor_col = shadow_col[shadow_cterm];
        res.cursor_row = shadow_row[shadow_cterm];
        res.cursor_offset = OFS_W'(shadow_row[shadow_cterm] * COLUMNS
                                   + shadow_col[shadow_cterm]);
        return res;
    endfunction

    // Driver: takes words from the pending queue with a random gap before each.
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= $urandom_range(0, 19);
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_words.push_back(console_step(in_data));
                in_gap <= $urandom_range(0, 19);
                in_valid <= 1'b0;
            end
            else if (!in_valid && pending_words.size() > 0)
            begin
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
                else
                begin
                    in_data  <= pending_words.pop_front();
                    sent_count++;
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: random stall per word, plus a long hold-off on request.
    int out_stall;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected: %h", out_data);
                    error_count++;
                end
                else
                begin
                    out_word_t want;
                    want = expected_words.pop_front();
                    checked_count++;
                    if (out_data.cursor_col !== want.cursor_col)
                    begin
                        $error("cursor_col expected %0d actual %0d",
                               want.cursor_col, out_data.cursor_col);
                        error_count++;
                    end
                    if (out_data.cursor_row !== want.cursor_row)
                    begin
                        $error("cursor_row expected %0d actual %0d",
                               want.cursor_row, out_data.cursor_row);
                        error_count++;
                    end
                    if (out_data.cursor_offset !== want.cursor_offset)
                    begin
                        $error("cursor_offset expected %0d actual %0d",
                               want.cursor_offset, out_data.cursor_offset);
                        error_count++;
                    end
                    if (out_data.cell_char !== want.cell_char)
                    begin
                        $error("cell_char expected %0d actual %0d",
                               want.cell_char, out_data.cell_char);
                        error_count++;
                    end
                    if (out_data.cell_attr !== want.cell_attr)
                    begin
                        $error("cell_attr expected %0d actual %0d",
                               want.cell_attr, out_data.cell_attr);
                        error_count++;
                    end
                end
            end
            if (hold_active)
            begin
                // The long hold-off lets the input side back up behind the block.
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                out_stall <= $urandom_range(0, 19);
                out_ready <= 1'b0;
            end
            else if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Writes one register while the block is idle and mirrors it in the shadow state.
    task automatic write_register(input logic idx, input logic [1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_WRITE_TERM)
        begin
            if (value >= 1 && value < TERMINALS)
                shadow_wterm = value;
        end
        else if (value < TERMINALS)
            shadow_cterm = value;
    endtask

    // Waits until the pending queue is empty and every word sent has been checked.
    task automatic drain_all();
        wait (pending_words.size() == 0 && sent_count == checked_count);
        repeat (50) @(posedge clk);
    endtask

    function automatic in_word_t make_word(cmd_t c);
        in_word_t w;
        w = $bits(in_word_t)'({$urandom, $urandom});
        w.cmd = c;
        return w;
    endfunction

    // Cheap commands dominate; sweeps are rare since each one visits every cell of a buffer.
    function automatic in_word_t random_word();
        in_word_t w;
        int       pick;
        w = $bits(in_word_t)'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            w.cmd = CMD_PUT;
            if ($urandom_range(0, 9) == 0)
                w.char_code = ($urandom_range(0, 1) != 0) ? CHAR_LF : CHAR_CR;
        end
        else if (pick < 55)
            w.cmd = CMD_BS;
        else if (pick < 57)
            w.cmd = ($urandom_range(0, 1) != 0) ? CMD_CLR : CMD_CLRH;
        else if (pick < 60)
            w.cmd = CMD_HOME;
        else if (pick < 68)
            w.cmd = CMD_SETC;
        else if (pick < 75)
            w.cmd = CMD_MATTR;
        else if (pick < 77)
            w.cmd = CMD_SHOW;
        else if (pick < 97)
            w.cmd = CMD_READ;
        else
            w.cmd = 4'($urandom_range(9, 15));
        // Mostly in-range coordinates, sometimes raw values that can lie beyond the screen.
        if ($urandom_range(0, 7) != 0)
        begin
            w.col = COL_W'($urandom_range(0, COLUMNS - 1));
            w.row = ROW_W'($urandom_range(0, ROWS - 1));
        end
        return w;
    endfunction

    initial
    begin
        in_word_t w;
        error_count = 0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        for (int t = 0; t < TERMINALS; t++)
        begin
            blank_buffer(t);
            shadow_col[t] = '0;
            shadow_row[t] = '0;
        end
        shadow_wterm = 1;
        shadow_cterm = 1;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: edges of each field and each special case.
        w = make_word(CMD_BS);
        w.line_full = 1'b1;
        pending_words.push_back(w);                    // backspace at the top-left
        w = make_word(CMD_READ);
        w.col = '0; w.row = '0; w.buffer_sel = 2'd1;
        pending_words.push_back(w);
        w = make_word(CMD_SETC);
        w.col = 7'h7f; w.row = 5'h1f;
        pending_words.push_back(w);                    // saturates to the last cell
        w = make_word(CMD_PUT);
        w.char_code = 8'hff;
        pending_words.push_back(w);                    // wraps and scrolls
        w = make_word(CMD_PUT);
        w.char_code = 8'h00;
        pending_words.push_back(w);
        w = make_word(CMD_PUT);
        w.char_code = CHAR_LF;
        pending_words.push_back(w);
        w = make_word(CMD_PUT);
        w.char_code = CHAR_CR;
        pending_words.push_back(w);
        w = make_word(CMD_BS);
        w.line_full = 1'b0;
        pending_words.push_back(w);
        w = make_word(CMD_BS);
        w.line_full = 1'b1;
        pending_words.push_back(w);                    // to the end of the line above
        w = make_word(CMD_MATTR);
        w.col = LAST_COL; w.row = LAST_ROW; w.attr_value = 8'hff;
        pending_words.push_back(w);
        w = make_word(CMD_MATTR);
        w.col = 7'd80; w.row = 5'd0;
        pending_words.push_back(w);                    // off screen, nothing written
        w = make_word(CMD_READ);
        w.col = LAST_COL; w.row = LAST_ROW; w.buffer_sel = 2'd1;
        pending_words.push_back(w);
        w = make_word(CMD_READ);
        w.col = 7'h7f; w.row = 5'h1f; w.buffer_sel = 2'd3;
        pending_words.push_back(w);                    // out of range reads zero
        w = make_word(CMD_SHOW);
        pending_words.push_back(w);
        w = make_word(CMD_READ);
        w.col = LAST_COL; w.row = LAST_ROW; w.buffer_sel = '0;
        pending_words.push_back(w);
        pending_words.push_back(make_word(CMD_HOME));
        pending_words.push_back(make_word(CMD_CLR));
        pending_words.push_back(make_word(CMD_CLRH));
        w = make_word(CMD_HOME);
        w.cmd = 4'hf;
        pending_words.push_back(w);                    // unused code
        drain_all();

        // Register settings, extremes and illegal writes among them.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin write_register(CFG_WRITE_TERM, 2'd3);
                         write_register(CFG_CURSOR_TERM, 2'd3); end
                1: begin write_register(CFG_WRITE_TERM, 2'd0);
                         write_register(CFG_CURSOR_TERM, 2'd0); end
                2: begin write_register(CFG_WRITE_TERM, 2'd2);
                         write_register(CFG_CURSOR_TERM, 2'd2); end
                3: begin write_register(CFG_WRITE_TERM, 2'd1);
                         write_register(CFG_CURSOR_TERM, 2'd1); end
                default:
                begin
                    write_register(CFG_WRITE_TERM, 2'($urandom));
                    write_register(CFG_CURSOR_TERM, 2'($urandom));
                end
            endcase
            for (int n = 0; n < 128; n++)
                pending_words.push_back(random_word());
            if (phase == 2)
            begin
                // Receiver holds off long enough for the block to back up.
                wait (expected_words.size() > 0);
                hold_go = 1'b1;
            end
            drain_all();
        end

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Worst case: many sweeps plus the initial clear.
    initial
    begin
        #30ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
